### hdl/e2rt_pkg.sv
// package for the euler to rigid transform unit
// widths, cordic constants, payload types and fixed-point helpers
package e2rt_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int COEFF_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int TRANS_BITS    = 32;
  localparam int WORK_FRAC     = 30;
  localparam int WORK_BITS     = 34;
  localparam int STAGE_BITS    = $clog2(CORDIC_STAGES);

  localparam logic signed [WORK_BITS-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [WORK_BITS-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [WORK_BITS-1:0] HALF_PI_Q30 = 34'sd1686629713;

  typedef logic signed [WORK_BITS-1:0] work_t;

  typedef struct packed {
    logic signed [TRANS_BITS-1:0] trans_x;
    logic signed [TRANS_BITS-1:0] trans_y;
    logic signed [TRANS_BITS-1:0] trans_z;
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
  } pose_t;

  typedef struct packed {
    logic signed [COEFF_BITS-1:0] rot_00;
    logic signed [COEFF_BITS-1:0] rot_01;
    logic signed [COEFF_BITS-1:0] rot_02;
    logic signed [COEFF_BITS-1:0] rot_10;
    logic signed [COEFF_BITS-1:0] rot_11;
    logic signed [COEFF_BITS-1:0] rot_12;
    logic signed [COEFF_BITS-1:0] rot_20;
    logic signed [COEFF_BITS-1:0] rot_21;
    logic signed [COEFF_BITS-1:0] rot_22;
    logic signed [TRANS_BITS-1:0] out_tx;
    logic signed [TRANS_BITS-1:0] out_ty;
    logic signed [TRANS_BITS-1:0] out_tz;
  } xform_t;

  typedef struct packed {
    work_t x;
    work_t y;
    work_t z;
    logic  neg;
  } cordic_t;

  function automatic work_t atan_q30(input logic [4:0] i);
    work_t r;
    case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      5'd24: r = 34'sd64;
      5'd25: r = 34'sd32;
      5'd26: r = 34'sd16;
      5'd27: r = 34'sd8;
      5'd28: r = 34'sd4;
      5'd29: r = 34'sd2;
      5'd30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // q4.30 product, round half up
  function automatic work_t qmul(input work_t a, input work_t b);
    logic signed [2*WORK_BITS-1:0] p;
    p = a * b + (68'sd1 <<< (WORK_FRAC - 1));
    return work_t'(p >>> WORK_FRAC);
  endfunction

  function automatic logic signed [COEFF_BITS-1:0] to_coeff(input work_t v);
    work_t r;
    work_t one;
    one = work_t'(1) <<< (COEFF_BITS - 2);
    r = (v + (work_t'(1) <<< (31 - COEFF_BITS))) >>> (32 - COEFF_BITS);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[COEFF_BITS-1:0];
  endfunction

endpackage

### hdl/e2rt_stream_if.sv
// valid/ready channel interface carrying a payload of any packed type
// no dependencies
interface e2rt_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/e2rt_cordic_stage.sv
// one cordic micro-rotation register stage for the shift given by idx
// depends on e2rt_pkg
module e2rt_cordic_stage (
  input  logic                                clk,
  input  logic                                en,
  input  logic [e2rt_pkg::STAGE_BITS-1:0]     idx,
  input  e2rt_pkg::cordic_t                   din,
  output e2rt_pkg::cordic_t                   dout_r
);
  e2rt_pkg::cordic_t dout_nxt;
  e2rt_pkg::work_t   xs;
  e2rt_pkg::work_t   ys;
  e2rt_pkg::work_t   at;

  always_comb begin
    xs = din.x >>> idx;
    ys = din.y >>> idx;
    at = e2rt_pkg::atan_q30(5'(idx));
    dout_nxt.neg = din.neg;
    if (!din.z[e2rt_pkg::WORK_BITS-1]) begin
      dout_nxt.x = din.x - ys;
      dout_nxt.y = din.y + xs;
      dout_nxt.z = din.z - at;
    end else begin
      dout_nxt.x = din.x + ys;
      dout_nxt.y = din.y - xs;
      dout_nxt.z = din.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout_r <= dout_nxt;
  end
endmodule

### hdl/e2rt_sincos.sv
// pipelined sine/cosine: fold stage, one register stage per cordic step, then a sign stage
// depends on e2rt_pkg and e2rt_cordic_stage
module e2rt_sincos (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [e2rt_pkg::ANGLE_BITS-1:0] angle,
  output e2rt_pkg::work_t                       sin_r,
  output e2rt_pkg::work_t                       cos_r
);
  e2rt_pkg::cordic_t pipe [0:e2rt_pkg::CORDIC_STAGES];
  e2rt_pkg::cordic_t fold_nxt;
  e2rt_pkg::work_t   z0;

  always_comb begin
    z0 = e2rt_pkg::work_t'(angle) <<< (33 - e2rt_pkg::ANGLE_BITS);
    fold_nxt.x = e2rt_pkg::GAIN_Q30;
    fold_nxt.y = '0;
    fold_nxt.neg = 1'b0;
    fold_nxt.z = z0;
    if (z0 > e2rt_pkg::HALF_PI_Q30) begin
      fold_nxt.z = z0 - e2rt_pkg::PI_Q30;
      fold_nxt.neg = 1'b1;
    end else if (z0 < -e2rt_pkg::HALF_PI_Q30) begin
      fold_nxt.z = z0 + e2rt_pkg::PI_Q30;
      fold_nxt.neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) pipe[0] <= fold_nxt;
  end

  for (genvar i = 0; i < e2rt_pkg::CORDIC_STAGES; i++) begin : g_stage
    e2rt_cordic_stage u_stage (
      .clk    (clk),
      .en     (en),
      .idx    (e2rt_pkg::STAGE_BITS'(i)),
      .din    (pipe[i]),
      .dout_r (pipe[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= pipe[e2rt_pkg::CORDIC_STAGES].neg ? -pipe[e2rt_pkg::CORDIC_STAGES].y
                                                 :  pipe[e2rt_pkg::CORDIC_STAGES].y;
      cos_r <= pipe[e2rt_pkg::CORDIC_STAGES].neg ? -pipe[e2rt_pkg::CORDIC_STAGES].x
                                                 :  pipe[e2rt_pkg::CORDIC_STAGES].x;
    end
  end
endmodule

### hdl/e2rt_matrix.sv
// three-stage product and rounding pipeline building the rotation matrix
// depends on e2rt_pkg
module e2rt_matrix (
  input  logic            clk,
  input  logic            en,
  input  e2rt_pkg::work_t sr, cr, sp, cp, sy, cy,
  output logic signed [e2rt_pkg::COEFF_BITS-1:0] m_r [0:8]
);
  e2rt_pkg::work_t a_r [0:9];
  e2rt_pkg::work_t keep_r [0:2];
  e2rt_pkg::work_t b_r [0:8];

  // first products and pass-through factors for the triple products
  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= e2rt_pkg::qmul(cy, cp);
      a_r[1] <= e2rt_pkg::qmul(sr, sy);
      a_r[2] <= e2rt_pkg::qmul(cr, sy);
      a_r[3] <= e2rt_pkg::qmul(cy, sp);
      a_r[4] <= e2rt_pkg::qmul(cp, sr);
      a_r[5] <= e2rt_pkg::qmul(cp, sy);
      a_r[6] <= e2rt_pkg::qmul(cy, sr);
      a_r[7] <= e2rt_pkg::qmul(cr, cy);
      a_r[8] <= e2rt_pkg::qmul(sy, sp);
      a_r[9] <= e2rt_pkg::qmul(cr, sp);
      keep_r[0] <= sp;
      keep_r[1] <= sy;
      keep_r[2] <= sr;
      b_r[8] <= e2rt_pkg::qmul(cr, cp);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r[0] <= a_r[0] - e2rt_pkg::qmul(a_r[1], keep_r[0]);
      b_r[1] <= -a_r[2];
      b_r[2] <= a_r[3] + e2rt_pkg::qmul(a_r[4], keep_r[1]);
      b_r[3] <= a_r[5] + e2rt_pkg::qmul(a_r[6], keep_r[0]);
      b_r[4] <= a_r[7];
      b_r[5] <= a_r[8] - e2rt_pkg::qmul(a_r[0], keep_r[2]);
      b_r[6] <= -a_r[9];
      b_r[7] <= keep_r[2];
    end
  end

  e2rt_pkg::work_t b8_d_r;
  always_ff @(posedge clk) begin
    if (en) begin
      b8_d_r <= b_r[8];
      for (int k = 0; k < 8; k++) m_r[k] <= e2rt_pkg::to_coeff(b_r[k]);
      m_r[8] <= e2rt_pkg::to_coeff(b8_d_r);
    end
  end
endmodule

### hdl/euler_to_rigid_transform_unit.sv
// top level: pose in, rotation matrix and translation out
// depends on e2rt_pkg, e2rt_stream_if, e2rt_sincos, e2rt_matrix
//
// usage
//   in_ch carries one pose per transaction (translation q16.16, angles q3.13);
//   out_ch carries the nine q2.14 rotation entries and the unchanged
//   translation. a transaction completes when valid and ready are both high.
//   the datapath is a single stalling pipeline: a fold stage, one stage per
//   cordic step (16), a sign stage, three product and rounding stages.
//   one pose is taken every cycle while the output side accepts. the cordic
//   chain sets the depth. when the receiver holds ready low while out_valid
//   is high the whole pipeline freezes, so nothing is lost or repeated, and
//   in_ready falls with out_ready unless the output register is empty.
//   reset (synchronous, rst_n low) clears all valid bits; payload registers
//   are not reset. the block keeps no state between poses.
module euler_to_rigid_transform_unit (
  input  logic clk,
  input  logic rst_n,
  e2rt_stream_if.sink   in_ch,
  e2rt_stream_if.source out_ch
);
  localparam int DEPTH = e2rt_pkg::CORDIC_STAGES + 5;

  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] vld_nxt;
  logic             en;
  logic signed [e2rt_pkg::TRANS_BITS-1:0] tx_r [0:DEPTH-1];
  logic signed [e2rt_pkg::TRANS_BITS-1:0] ty_r [0:DEPTH-1];
  logic signed [e2rt_pkg::TRANS_BITS-1:0] tz_r [0:DEPTH-1];
  e2rt_pkg::work_t sr, cr, sp, cp, sy, cy;
  logic signed [e2rt_pkg::COEFF_BITS-1:0] m [0:8];

  assign en = out_ch.ready || !vld_r[DEPTH-1];
  assign in_ch.ready = en;
  assign vld_nxt = {vld_r[DEPTH-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r[0] <= in_ch.data.trans_x;
      ty_r[0] <= in_ch.data.trans_y;
      tz_r[0] <= in_ch.data.trans_z;
      for (int k = 1; k < DEPTH; k++) begin
        tx_r[k] <= tx_r[k-1];
        ty_r[k] <= ty_r[k-1];
        tz_r[k] <= tz_r[k-1];
      end
    end
  end

  e2rt_sincos u_roll  (.clk(clk), .en(en), .angle(in_ch.data.roll_angle),  .sin_r(sr), .cos_r(cr));
  e2rt_sincos u_pitch (.clk(clk), .en(en), .angle(in_ch.data.pitch_angle), .sin_r(sp), .cos_r(cp));
  e2rt_sincos u_yaw   (.clk(clk), .en(en), .angle(in_ch.data.yaw_angle),   .sin_r(sy), .cos_r(cy));

  e2rt_matrix u_matrix (
    .clk(clk), .en(en), .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy), .m_r(m)
  );

  assign out_ch.valid       = vld_r[DEPTH-1];
  assign out_ch.data.rot_00 = m[0];
  assign out_ch.data.rot_01 = m[1];
  assign out_ch.data.rot_02 = m[2];
  assign out_ch.data.rot_10 = m[3];
  assign out_ch.data.rot_11 = m[4];
  assign out_ch.data.rot_12 = m[5];
  assign out_ch.data.rot_20 = m[6];
  assign out_ch.data.rot_21 = m[7];
  assign out_ch.data.rot_22 = m[8];
  assign out_ch.data.out_tx = tx_r[DEPTH-1];
  assign out_ch.data.out_ty = ty_r[DEPTH-1];
  assign out_ch.data.out_tz = tz_r[DEPTH-1];
endmodule
